>>> src/bdq_pkg.sv
// Package for the bounded deque with search: sizes, command and status
// codes, beat structs, controller types and the circular slot helper.
// No dependencies.
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FIND       = 3'd4,
    CMD_READ_AT    = 3'd5
  } bdq_cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } bdq_status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [3:0]  position;
  } bdq_in_t;

  typedef struct packed {
    logic [31:0] item_out;
    logic [3:0]  found_position;
    logic [4:0]  item_count;
    logic [2:0]  status;
  } bdq_out_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_READ = 2'd1,
    FSM_FIND = 2'd2
  } bdq_state_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // result register empty or draining this cycle
    logic go_read;    // offered command is an in-range read at
    logic go_find;    // offered command is a find on a non-empty deque
    logic scan_hit;   // compared entry matches the search value
    logic scan_end;   // every held entry compared, nothing in flight
  } bdq_sts_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic read_load;
    logic find_step;
    logic find_hit;
    logic find_miss;
  } bdq_ctl_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

>>> src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bdq_ctrl.sv
// Controller for the bounded deque: idle / read wait / find scan sequencing.
// Depends on bdq_pkg.
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdq_pkg::bdq_sts_t sts,
  output bdq_pkg::bdq_ctl_t ctl
);

  bdq_pkg::bdq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::FSM_IDLE: begin
        if (in_valid && sts.out_free) begin
          if (sts.go_read) begin
            state_nxt = bdq_pkg::FSM_READ;
          end else if (sts.go_find) begin
            state_nxt = bdq_pkg::FSM_FIND;
          end
        end
      end
      bdq_pkg::FSM_READ: begin
        state_nxt = bdq_pkg::FSM_IDLE;
      end
      bdq_pkg::FSM_FIND: begin
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = bdq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctl           = '0;
    unique case (state_r)
      bdq_pkg::FSM_IDLE: begin
        in_stall   = !sts.out_free;
        ctl.accept = in_valid && sts.out_free;
      end
      bdq_pkg::FSM_READ: begin
        ctl.read_load = 1'b1;
      end
      bdq_pkg::FSM_FIND: begin
        ctl.find_step = 1'b1;
        ctl.find_hit  = sts.scan_hit;
        ctl.find_miss = !sts.scan_hit && sts.scan_end;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> src/bdq_dp.sv
// Datapath for the bounded deque: head/count registers, item RAM, find scan
// pipeline and the result register. Depends on bdq_pkg and bdq_ram.
module bdq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::bdq_in_t  in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output bdq_pkg::bdq_out_t out_data,
  input  bdq_pkg::bdq_ctl_t ctl,
  output bdq_pkg::bdq_sts_t sts
);

  localparam int SW = bdq_pkg::SLOT_W;
  localparam int CW = bdq_pkg::CNT_W;
  localparam int IW = bdq_pkg::ITEM_WIDTH;

  logic [SW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] val_r, val_nxt;
  logic          out_valid_r, out_valid_nxt;
  bdq_pkg::bdq_out_t out_r, out_nxt;

  logic          full, empty, pos_ok, issue_en, imm_load;
  logic [CW-1:0] pos_ext;
  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic [IW-1:0] rdata;

  bdq_ram #(
    .WIDTH (IW),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data.value[IW-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full     = (count_r == CW'(bdq_pkg::DEPTH));
  assign empty    = (count_r == '0);
  assign pos_ext  = CW'(in_data.position);
  assign pos_ok   = (pos_ext < count_r);
  assign issue_en = (idx_r < count_r);

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.go_read  = (in_data.command == bdq_pkg::CMD_READ_AT) && pos_ok;
  assign sts.go_find  = (in_data.command == bdq_pkg::CMD_FIND) && !empty;
  assign sts.scan_hit = cmp_vld_r && (rdata == val_r);
  assign sts.scan_end = !cmp_vld_r && !issue_en;

  assign imm_load = ctl.accept && !sts.go_read && !sts.go_find;
  assign raddr    = ctl.find_step ? bdq_pkg::slot_add(head_r, idx_r)
                                  : bdq_pkg::slot_add(head_r, pos_ext);

  // command decode: state update, RAM write and immediate result
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = bdq_pkg::slot_add(head_r, count_r);
    out_nxt   = out_r;
    if (ctl.accept) begin
      out_nxt = '0;
      case (in_data.command)
        bdq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            out_nxt.status = bdq_pkg::ST_FULL;
          end else begin
            head_nxt  = (head_r == '0) ? SW'(bdq_pkg::DEPTH - 1) : head_r - 1'b1;
            waddr     = head_nxt;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            out_nxt.status = bdq_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            out_nxt.status = bdq_pkg::ST_EMPTY;
          end else begin
            head_nxt  = bdq_pkg::slot_add(head_r, CW'(1));
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            out_nxt.status = bdq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::CMD_FIND: begin
          out_nxt.status = bdq_pkg::ST_NOT_FOUND;
        end
        bdq_pkg::CMD_READ_AT: begin
          out_nxt.status = bdq_pkg::ST_RANGE;
        end
        default: begin
          out_nxt.status = bdq_pkg::ST_OK;
        end
      endcase
      out_nxt.item_count = 5'(count_nxt);
    end else if (ctl.read_load) begin
      out_nxt            = '0;
      out_nxt.item_out   = 32'(rdata);
      out_nxt.item_count = 5'(count_r);
      out_nxt.status     = bdq_pkg::ST_OK;
    end else if (ctl.find_hit) begin
      out_nxt                = '0;
      out_nxt.found_position = 4'(cmp_idx_r);
      out_nxt.item_count     = 5'(count_r);
      out_nxt.status         = bdq_pkg::ST_OK;
    end else if (ctl.find_miss) begin
      out_nxt            = '0;
      out_nxt.item_count = 5'(count_r);
      out_nxt.status     = bdq_pkg::ST_NOT_FOUND;
    end
  end

  // find scan: issue one read a cycle, compare the one issued before
  always_comb begin
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    val_nxt     = val_r;
    if (ctl.accept) begin
      idx_nxt     = '0;
      cmp_vld_nxt = 1'b0;
      val_nxt     = in_data.value[IW-1:0];
    end else if (ctl.find_step) begin
      cmp_vld_nxt = issue_en;
      cmp_idx_nxt = idx_r[SW-1:0];
      if (issue_en) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (imm_load || ctl.read_load || ctl.find_hit || ctl.find_miss) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    val_r     <= val_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/bounded_deque_with_search.sv
// Top level of the bounded deque with search: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl, bdq_dp (and through it bdq_ram).
//
// Usage:
//   in_valid / in_stall / in_data carry one command beat (command, value,
//   position). out_valid / out_stall / out_data carry one result beat per
//   command (item_out, found_position, item_count, status).
//   A beat moves at a rising edge with valid high and stall low.
// Timing and throughput:
//   Inserts, removes, rejected commands and unused codes finish in the
//   accept cycle: the result shows in the next cycle, and while out_stall
//   is low one command is taken a cycle. An in-range read at waits on the
//   registered RAM read, then the read state loads the result register.
//   A find streams one entry a cycle through the RAM read port and its
//   comparator; a hit ends the scan early, a miss once all are compared.
//   One command is worked on at a time.
// Reset:
//   rst_n low (synchronous) empties the deque and drops any pending result.
//   Storage contents are not cleared; only held positions are ever read.
// Stall:
//   While out_stall holds a result, the result register holds its beat and
//   in_stall stays high, so no command is lost or reordered.
module bounded_deque_with_search (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdq_pkg::bdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bdq_pkg::bdq_out_t out_data
);

  bdq_pkg::bdq_sts_t sts;
  bdq_pkg::bdq_ctl_t ctl;

  // sequence the command: accept, read wait, find scan
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // hold the deque state, storage and result register
  bdq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

  // no new beat is taken while a read or a scan is under way
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.read_load || ctl.find_step) |-> in_stall)
    else $error("command accepted while busy");

  // a command that completes at once shows its result next cycle
  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.accept && !sts.go_read && !sts.go_find) |=> out_valid)
    else $error("immediate result missing");

  // a find hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.find_hit |=> (out_valid && out_data.status == bdq_pkg::ST_OK))
    else $error("find hit without ok status");

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.item_count <= 5'(bdq_pkg::DEPTH)))
    else $error("item count above capacity");

endmodule
